// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lpbd_pkg.sv =====
package lpbd_pkg;

    // Frame layout.
    localparam int HEADER_BYTES          = 8;
    localparam int ENVELOPE_PREFIX_BYTES = 12;
    localparam int MAX_BURST             = 8;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_MESSAGE_SIZE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BATCH_TYPE       = 1'b1;

    // Result status codes.
    typedef logic [2:0] status_t;
    localparam status_t STATUS_DATA          = 3'd0;
    localparam status_t STATUS_BAD_OUTER     = 3'd1;
    localparam status_t STATUS_SHORT_ENV     = 3'd2;
    localparam status_t STATUS_BAD_INNER     = 3'd3;
    localparam status_t STATUS_COMPRESSED    = 3'd4;

    // Parser position within the stream.
    typedef enum logic [2:0] {
        MODE_OUTER_HDR,
        MODE_OUTER_BODY,
        MODE_PREFIX,
        MODE_INNER_HDR,
        MODE_INNER_BODY,
        MODE_SKIP
    } mode_t;

    // One delivered result.
    typedef struct packed {
        logic [7:0]  data;
        logic [31:0] msg_type;
        logic        first_flag;
        logic        last_flag;
        status_t     status;
    } res_t;

endpackage

// ===== src/length_prefixed_batch_deframer_unit.sv =====
// Length-prefixed batch deframer.
// Input channel: in_valid / in_stall / data_byte, one raw stream byte per request.
// Output channel: out_valid / out_stall with out_byte, msg_type, first_of_msg,
// last_of_msg and status, one delivered byte or one error code per request.
// Configuration: cfg_wr_en / cfg_index / cfg_data write max_message_size (index 0)
// and batch_type (index 1); write only while the block is idle.
// Each accepted byte is parsed in the cycle it is accepted and its results (none,
// one body byte, one error code, or an 8-byte header burst) are written into a
// result queue of FIFO_DEPTH entries; the first result shows in the next cycle.
// The input takes one byte per cycle while the queue has room for a full
// burst (at most FIFO_DEPTH - 8 entries held); the output drains one result per
// cycle while out_stall is low, so over a frame the block keeps pace with the link.
// When the receiver stalls, the queue fills and in_stall rises; nothing is lost.
// A length error delivers one result with a nonzero status and then halts the
// parser until reset; later bytes are accepted and dropped.
// Reset empties the queue, returns the parser to the outer header and loads
// the register defaults (max_message_size 65535, batch_type 0).
module length_prefixed_batch_deframer_unit #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lpbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_byte,
    output logic [31:0]                     msg_type,
    output logic                            first_of_msg,
    output logic                            last_of_msg,
    output lpbd_pkg::status_t               status
);
    import lpbd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration registers.
    logic [31:0] max_size_reg;
    logic [31:0] batch_type_reg;

    // Parser state.
    mode_t       mode_reg, mode_next;
    logic [63:0] hdr_reg, hdr_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] outer_rem_reg, outer_rem_next;
    logic [31:0] inner_rem_reg, inner_rem_next;
    logic [31:0] cur_type_reg, cur_type_next;
    logic        halted_reg, halted_next;

    // Result queue.
    res_t             fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic       in_acc, out_acc, step;
    res_t       res [MAX_BURST];
    logic [3:0] push_n;

    logic [63:0] hdr_coll;
    logic [31:0] size, htype, body_len, outer_dec;
    logic        hdr_done, size_low, outer_bad, inner_bad;

    // Handshakes.
    assign in_stall  = count_reg > CNT_W'(FIFO_DEPTH - MAX_BURST);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = count_reg != '0;
    assign out_acc   = out_valid && !out_stall;
    assign step      = in_acc && !halted_reg;

    // Queue head drives the output payload.
    assign out_byte     = fifo_reg[rd_ptr_reg].data;
    assign msg_type     = fifo_reg[rd_ptr_reg].msg_type;
    assign first_of_msg = fifo_reg[rd_ptr_reg].first_flag;
    assign last_of_msg  = fifo_reg[rd_ptr_reg].last_flag;
    assign status       = fifo_reg[rd_ptr_reg].status;

    // Shared header arithmetic.
    assign hdr_coll  = hdr_reg | ({56'b0, data_byte} << {cnt_reg, 3'b000});
    assign size      = hdr_coll[31:0];
    assign htype     = hdr_coll[63:32];
    assign hdr_done  = cnt_reg == 3'(HEADER_BYTES - 1);
    assign body_len  = size - 32'(HEADER_BYTES);
    assign outer_dec = outer_rem_reg - 32'd1;
    assign size_low  = size < 32'(HEADER_BYTES);
    assign outer_bad = size_low || (size > max_size_reg);
    assign inner_bad = size_low || (body_len > outer_dec);

    // Where to go after an inner message or the envelope prefix ends.
    function automatic mode_t env_mode(input logic [31:0] rem);
        if (rem == 32'd0)
            return MODE_OUTER_HDR;
        else if (rem < 32'(HEADER_BYTES))
            return MODE_SKIP;
        else
            return MODE_INNER_HDR;
    endfunction

    // Queue slot a given distance past the write pointer.
    function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] base, input int ofs);
        logic [PTR_W:0] s;
        s = {1'b0, base} + (PTR_W+1)'(ofs);
        if (s >= (PTR_W+1)'(FIFO_DEPTH))
            s = s - (PTR_W+1)'(FIFO_DEPTH);
        return s[PTR_W-1:0];
    endfunction

    // Parser next state.
    always_comb
    begin
        mode_next      = mode_reg;
        hdr_next       = hdr_reg;
        cnt_next       = cnt_reg;
        outer_rem_next = outer_rem_reg;
        inner_rem_next = inner_rem_reg;
        cur_type_next  = cur_type_reg;
        halted_next    = halted_reg;
        if (step)
        begin
            case (mode_reg)
                MODE_OUTER_HDR:
                begin
                    hdr_next = hdr_coll;
                    cnt_next = cnt_reg + 3'd1;
                    if (hdr_done)
                    begin
                        hdr_next = '0;
                        cnt_next = '0;
                        outer_rem_next = body_len;
                        if (outer_bad)
                            halted_next = 1'b1;
                        else if (htype == batch_type_reg)
                        begin
                            if (size < 32'(ENVELOPE_PREFIX_BYTES))
                                halted_next = 1'b1;
                            else
                                mode_next = MODE_PREFIX;
                        end
                        else
                        begin
                            cur_type_next = htype;
                            mode_next = (body_len == 32'd0) ? MODE_OUTER_HDR : MODE_OUTER_BODY;
                        end
                    end
                end
                MODE_OUTER_BODY:
                begin
                    outer_rem_next = outer_dec;
                    if (outer_rem_reg == 32'd1)
                        mode_next = MODE_OUTER_HDR;
                end
                MODE_PREFIX:
                begin
                    if (cnt_reg == 3'd0 && data_byte == 8'd1)
                        halted_next = 1'b1;
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                        outer_rem_next = outer_dec;
                        if (cnt_reg == 3'(ENVELOPE_PREFIX_BYTES - HEADER_BYTES - 1))
                        begin
                            hdr_next  = '0;
                            cnt_next  = '0;
                            mode_next = env_mode(outer_dec);
                        end
                    end
                end
                MODE_INNER_HDR:
                begin
                    hdr_next = hdr_coll;
                    cnt_next = cnt_reg + 3'd1;
                    outer_rem_next = outer_dec;
                    if (hdr_done)
                    begin
                        hdr_next = '0;
                        cnt_next = '0;
                        if (inner_bad)
                            halted_next = 1'b1;
                        else
                        begin
                            cur_type_next  = htype;
                            inner_rem_next = body_len;
                            mode_next = (body_len == 32'd0) ? env_mode(outer_dec)
                                                            : MODE_INNER_BODY;
                        end
                    end
                end
                MODE_INNER_BODY:
                begin
                    inner_rem_next = inner_rem_reg - 32'd1;
                    outer_rem_next = outer_dec;
                    if (inner_rem_reg == 32'd1)
                    begin
                        hdr_next  = '0;
                        cnt_next  = '0;
                        mode_next = env_mode(outer_dec);
                    end
                end
                MODE_SKIP:
                begin
                    if (outer_rem_reg != 32'd0)
                        outer_rem_next = outer_dec;
                    if (outer_rem_reg <= 32'd1)
                    begin
                        hdr_next  = '0;
                        cnt_next  = '0;
                        mode_next = MODE_OUTER_HDR;
                    end
                end
                default:
                begin
                    hdr_next  = '0;
                    cnt_next  = '0;
                    mode_next = MODE_OUTER_HDR;
                end
            endcase
        end
    end

    // Results produced by the accepted byte.
    always_comb
    begin
        push_n = 4'd0;
        for (int i = 0; i < MAX_BURST; i++)
        begin
            res[i] = '0;
        end
        if (step)
        begin
            case (mode_reg)
                MODE_OUTER_HDR, MODE_INNER_HDR:
                begin
                    if (hdr_done)
                    begin
                        if (mode_reg == MODE_OUTER_HDR && outer_bad)
                        begin
                            push_n = 4'd1;
                            res[0].status = STATUS_BAD_OUTER;
                        end
                        else if (mode_reg == MODE_INNER_HDR && inner_bad)
                        begin
                            push_n = 4'd1;
                            res[0].status = STATUS_BAD_INNER;
                        end
                        else if (mode_reg == MODE_OUTER_HDR && htype == batch_type_reg)
                        begin
                            if (size < 32'(ENVELOPE_PREFIX_BYTES))
                            begin
                                push_n = 4'd1;
                                res[0].status = STATUS_SHORT_ENV;
                            end
                        end
                        else
                        begin
                            push_n = 4'(MAX_BURST);
                            for (int i = 0; i < MAX_BURST; i++)
                            begin
                                res[i].data       = hdr_coll[8*i +: 8];
                                res[i].msg_type   = htype;
                                res[i].first_flag = (i == 0);
                                res[i].last_flag  = (i == MAX_BURST - 1) && (body_len == 32'd0);
                                res[i].status     = STATUS_DATA;
                            end
                        end
                    end
                end
                MODE_OUTER_BODY, MODE_INNER_BODY:
                begin
                    push_n = 4'd1;
                    res[0].data     = data_byte;
                    res[0].msg_type = cur_type_reg;
                    res[0].last_flag = (mode_reg == MODE_OUTER_BODY) ? (outer_rem_reg == 32'd1)
                                                                    : (inner_rem_reg == 32'd1);
                end
                MODE_PREFIX:
                begin
                    if (cnt_reg == 3'd0 && data_byte == 8'd1)
                    begin
                        push_n = 4'd1;
                        res[0].status = STATUS_COMPRESSED;
                    end
                end
                default:
                begin
                    push_n = 4'd0;
                end
            endcase
        end
    end

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = slot(wr_ptr_reg, int'(push_n));
        rd_ptr_next = rd_ptr_reg;
        if (out_acc)
            rd_ptr_next = slot(rd_ptr_reg, 1);
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(out_acc);
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_BURST; i++)
        begin
            if (4'(i) < push_n)
                fifo_reg[slot(wr_ptr_reg, i)] <= res[i];
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg   <= 32'd65535;
            batch_type_reg <= 32'd0;
            mode_reg       <= MODE_OUTER_HDR;
            hdr_reg        <= '0;
            cnt_reg        <= '0;
            outer_rem_reg  <= '0;
            inner_rem_reg  <= '0;
            cur_type_reg   <= '0;
            halted_reg     <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_MAX_MESSAGE_SIZE: max_size_reg   <= cfg_data;
                    REG_BATCH_TYPE:       batch_type_reg <= cfg_data;
                    default:              max_size_reg   <= max_size_reg;
                endcase
            end
            mode_reg      <= mode_next;
            hdr_reg       <= hdr_next;
            cnt_reg       <= cnt_next;
            outer_rem_reg <= outer_rem_next;
            inner_rem_reg <= inner_rem_next;
            cur_type_reg  <= cur_type_next;
            halted_reg    <= halted_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
        end
    end

endmodule

// ===== src/lpbd_checker.sv =====
`include "assert_macros.svh"

module lpbd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [7:0]        data_byte,
    input logic              out_valid,
    input logic              out_stall,
    input logic [7:0]        out_byte,
    input logic [31:0]       msg_type,
    input logic              first_of_msg,
    input logic              last_of_msg,
    input lpbd_pkg::status_t status
);
    import lpbd_pkg::*;

    logic in_held;
    logic err_shown;
    logic err_taken;
    logic payload_clear;

    // Input request waiting, and error results as seen on the output channel.
    assign in_held       = in_valid && in_stall;
    assign err_shown     = out_valid && status != STATUS_DATA;
    assign err_taken     = err_shown && !out_stall;
    assign payload_clear = out_byte == 8'd0 && msg_type == 32'd0 && !first_of_msg
                           && !last_of_msg;

    // A stalled input request stays offered with the same byte.
    `LPBD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_held, in_valid && $stable(data_byte), "request dropped")

    // A stalled result stays offered.
    `LPBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")

    // An error result carries only its code.
    `LPBD_ASSERT_NOW(a_err_clean, clk, rst_n, err_shown, payload_clear, "error result has payload")

    // Nothing follows a delivered error until reset.
    `LPBD_ASSERT_NEXT(a_err_halts, clk, rst_n, err_taken, !out_valid, "result after error")

    // An empty result queue never holds off the input.
    `LPBD_ASSERT_NOW(a_no_stall_empty, clk, rst_n, !out_valid, !in_stall, "input stalled when empty")

endmodule

bind length_prefixed_batch_deframer_unit lpbd_checker u_lpbd_checker (.*);

// ===== verif/length_prefixed_batch_deframer_unit_test.sv =====
module length_prefixed_batch_deframer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lpbd_pkg::*;

    // Ordinary frame or batch envelope, as written in the directed table.
    typedef struct {
        bit          envelope;
        logic [31:0] size;      // total size of an ordinary frame
        logic [31:0] mtype;     // frame type, or type of the first inner message
        logic [7:0]  fill;      // body byte of an ordinary frame, flag byte of an envelope
        int          inner_a;   // body length of the first inner message, -1 for none
        int          inner_b;   // body length of the second inner message, -1 for none
        int          tail;      // bytes left over after the inner messages
    } frame_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             data_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             out_byte;
    logic [31:0]            msg_type;
    logic                   first_of_msg;
    logic                   last_of_msg;
    status_t                status;

    // Register copies kept by the testbench.
    logic [31:0] max_size_reg;
    logic [31:0] batch_type_reg;

    // Parser state of the predictor.
    logic [63:0] frame_hdr;
    int          hdr_fill;
    mode_t       parse_at;
    logic [31:0] frame_left;
    logic [31:0] msg_left;
    logic [31:0] msg_type_now;
    bit          stream_halted;

    res_t        byte_deliveries[$];
    res_t        expected_deliveries[$];
    logic [7:0]  frame_bytes[$];
    int          bytes_offered;
    int          fault_count;
    bit          in_steady;
    bit          out_steady;
    bit          receiver_hold;

    // Error codes raised by the closing request, one picked per run.
    localparam status_t CLOSING_CODES [4] = '{
        STATUS_BAD_OUTER, STATUS_SHORT_ENV, STATUS_BAD_INNER, STATUS_COMPRESSED
    };

    // Directed frames, sent with the registers at their reset values.
    frame_row_t directed_rows [8] = '{
        '{1'b0, 32'd8,  32'h0000_0001, 8'h00, -1, -1, 0},  // header-only frame
        '{1'b0, 32'd9,  32'hFFFF_FFFF, 8'hFF, -1, -1, 0},  // single body byte
        '{1'b0, 32'd12, 32'h8000_0001, 8'hA5, -1, -1, 0},
        '{1'b1, 32'd0,  32'h0000_0000, 8'h80,  0, -1, 0},  // header-only inner of batch type
        '{1'b1, 32'd0,  32'hFFFF_FFFF, 8'h00,  2,  1, 0},  // inner messages fill it exactly
        '{1'b1, 32'd0,  32'h0000_0002, 8'hFF, -1, -1, 0},  // prefix only
        '{1'b1, 32'd0,  32'h0000_0003, 8'h02, -1, -1, 7},  // short tail only
        '{1'b1, 32'd0,  32'h0000_0004, 8'h00,  1, -1, 3}   // short tail after a message
    };

    length_prefixed_batch_deframer_unit uut (.*);

    always #6 clk = ~clk;

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Queue appenders.
    function automatic void add_delivery(input res_t r);
        byte_deliveries.insert(byte_deliveries.size(), r);
    endfunction

    function automatic void add_stream_byte(input logic [7:0] b);
        frame_bytes.insert(frame_bytes.size(), b);
    endfunction

    // Predictor helpers.
    function automatic void clear_frame_hdr();
        frame_hdr = '0;
        hdr_fill  = 0;
    endfunction

    function automatic void emit_header(input logic [31:0] mtype, input bit no_body);
        for (int i = 0; i < HEADER_BYTES; i++)
            add_delivery(res_t'{data: frame_hdr[8*i +: 8], msg_type: mtype,
                                first_flag: (i == 0),
                                last_flag: (i == HEADER_BYTES - 1) && no_body,
                                status: STATUS_DATA});
    endfunction

    function automatic void halt_with(input status_t code);
        stream_halted = 1'b1;
        add_delivery(res_t'{data: 8'h00, msg_type: 32'h0, first_flag: 1'b0,
                            last_flag: 1'b0, status: code});
    endfunction

    // After an inner message or the prefix: next inner header, tail skip, or next frame.
    function automatic void next_msg_in_envelope();
        clear_frame_hdr();
        if (frame_left == 0)
            parse_at = MODE_OUTER_HDR;
        else if (frame_left < HEADER_BYTES)
            parse_at = MODE_SKIP;
        else
            parse_at = MODE_INNER_HDR;
    endfunction

    // Works out the deliveries caused by one accepted stream byte.
    function automatic void deframe_byte(input logic [7:0] b);
        logic [31:0] size;
        logic [31:0] ftype;
        if (stream_halted)
            return;
        case (parse_at)
            MODE_OUTER_HDR:
            begin
                frame_hdr[8*hdr_fill +: 8] = b;
                hdr_fill++;
                if (hdr_fill == HEADER_BYTES)
                begin
                    size  = frame_hdr[31:0];
                    ftype = frame_hdr[63:32];
                    if (size < HEADER_BYTES || size > max_size_reg)
                        halt_with(STATUS_BAD_OUTER);
                    else
                    begin
                        frame_left = size - HEADER_BYTES;
                        if (ftype == batch_type_reg)
                        begin
                            if (size < ENVELOPE_PREFIX_BYTES)
                                halt_with(STATUS_SHORT_ENV);
                            else
                            begin
                                clear_frame_hdr();
                                parse_at = MODE_PREFIX;
                            end
                        end
                        else
                        begin
                            msg_type_now = ftype;
                            emit_header(ftype, frame_left == 0);
                            clear_frame_hdr();
                            parse_at = (frame_left == 0) ? MODE_OUTER_HDR : MODE_OUTER_BODY;
                        end
                    end
                end
            end
            MODE_OUTER_BODY:
            begin
                add_delivery(res_t'{data: b, msg_type: msg_type_now, first_flag: 1'b0,
                                    last_flag: (frame_left == 1), status: STATUS_DATA});
                frame_left--;
                if (frame_left == 0)
                    parse_at = MODE_OUTER_HDR;
            end
            MODE_PREFIX:
            begin
                // Only the first prefix byte is the compression flag.
                if (hdr_fill == 0 && b == 8'd1)
                    halt_with(STATUS_COMPRESSED);
                else
                begin
                    hdr_fill++;
                    frame_left--;
                    if (hdr_fill >= ENVELOPE_PREFIX_BYTES - HEADER_BYTES)
                        next_msg_in_envelope();
                end
            end
            MODE_INNER_HDR:
            begin
                frame_hdr[8*hdr_fill +: 8] = b;
                hdr_fill++;
                frame_left--;
                if (hdr_fill == HEADER_BYTES)
                begin
                    size  = frame_hdr[31:0];
                    ftype = frame_hdr[63:32];
                    if (size < HEADER_BYTES || size - HEADER_BYTES > frame_left)
                        halt_with(STATUS_BAD_INNER);
                    else
                    begin
                        msg_type_now = ftype;
                        msg_left     = size - HEADER_BYTES;
                        emit_header(ftype, msg_left == 0);
                        if (msg_left == 0)
                            next_msg_in_envelope();
                        else
                        begin
                            clear_frame_hdr();
                            parse_at = MODE_INNER_BODY;
                        end
                    end
                end
            end
            MODE_INNER_BODY:
            begin
                add_delivery(res_t'{data: b, msg_type: msg_type_now, first_flag: 1'b0,
                                    last_flag: (msg_left == 1), status: STATUS_DATA});
                msg_left--;
                frame_left--;
                if (msg_left == 0)
                    next_msg_in_envelope();
            end
            MODE_SKIP:
            begin
                if (frame_left > 0)
                    frame_left--;
                if (frame_left == 0)
                begin
                    clear_frame_hdr();
                    parse_at = MODE_OUTER_HDR;
                end
            end
            default:
            begin
                clear_frame_hdr();
                parse_at = MODE_OUTER_HDR;
            end
        endcase
    endfunction

    // Frame builders: they append stream bytes to frame_bytes.
    function automatic void put_header(input logic [31:0] size, input logic [31:0] mtype);
        logic [63:0] hdr;
        hdr = {mtype, size};
        for (int i = 0; i < HEADER_BYTES; i++)
            add_stream_byte(hdr[8*i +: 8]);
    endfunction

    function automatic void put_plain(input logic [31:0] size, input logic [31:0] mtype,
                                      input logic [7:0] fill, input bit scramble);
        put_header(size, mtype);
        repeat (size - HEADER_BYTES)
            add_stream_byte(scramble ? 8'($urandom) : fill);
    endfunction

    function automatic void put_envelope(input logic [7:0] flag, input int lens[$],
                                         input int tail, input logic [31:0] first_type);
        logic [31:0] size;
        size = ENVELOPE_PREFIX_BYTES + tail;
        foreach (lens[j])
            size += HEADER_BYTES + lens[j];
        put_header(size, batch_type_reg);
        add_stream_byte(flag);
        // The other prefix bytes may hold a one, which must not count as compression.
        repeat (3)
            add_stream_byte(($urandom_range(0, 3) == 0) ? 8'h01 : 8'($urandom));
        foreach (lens[j])
        begin
            put_header(HEADER_BYTES + lens[j], first_type + j);
            repeat (lens[j])
                add_stream_byte(8'($urandom));
        end
        repeat (tail)
            add_stream_byte(8'($urandom));
    endfunction

    // Offers one byte, waits for the request to be taken, then predicts its deliveries.
    task automatic offer_byte(input logic [7:0] b, input bit use_typed = 1'b0,
                              input res_t typed = '0);
        int gap;
        gap = pick_gap(in_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_offered++;
        byte_deliveries.delete();
        deframe_byte(b);
        if (use_typed)
            expected_deliveries.insert(expected_deliveries.size(), typed);
        else
            foreach (byte_deliveries[i])
                expected_deliveries.insert(expected_deliveries.size(), byte_deliveries[i]);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            offer_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    // Idles the input and waits until every expected delivery has come out.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_deliveries.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == REG_MAX_MESSAGE_SIZE)
            max_size_reg = value;
        else if (idx == REG_BATCH_TYPE)
            batch_type_reg = value;
    endtask

    // Well-formed frame with random content within the current size limit.
    task automatic send_random_frame();
        longint      cap;
        longint      room;
        longint      len;
        logic [31:0] size;
        logic [31:0] mtype;
        logic [7:0]  flag;
        int          lens[$];
        int          tail;
        cap = max_size_reg;
        if ($urandom_range(0, 9) < 6)
        begin
            if (cap <= 300 && $urandom_range(0, 5) == 0)
                size = 32'(cap);
            else
                size = HEADER_BYTES + $urandom_range(0, (cap - 8 < 20) ? cap - 8 : 20);
            mtype = $urandom;
            if (mtype == batch_type_reg)
                mtype[0] = ~mtype[0];
            put_plain(size, mtype, 8'h00, 1'b1);
        end
        else
        begin
            room = (cap - 12 < 40) ? cap - 12 : 40;
            while (room >= 8 && lens.size() < 3 && $urandom_range(0, 3) != 0)
            begin
                len = $urandom_range(0, (room - 8 < 12) ? room - 8 : 12);
                lens.insert(lens.size(), int'(len));
                room -= 8 + len;
            end
            tail = $urandom_range(0, (room < 7) ? room : 7);
            flag = $urandom;
            if (flag == 8'd1)
                flag = 8'($urandom_range(2, 255));
            put_envelope(flag, lens, tail, $urandom);
        end
        send_frame();
    endtask

    task automatic run_random(input int budget, input bit keep_steady);
        int start;
        start = bytes_offered;
        while (bytes_offered - start < budget)
        begin
            if (!keep_steady && $urandom_range(0, 4) == 0)
                in_steady = !in_steady;
            send_random_frame();
        end
        in_steady = 1'b0;
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin : receiver_pacing
        int pause;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (receiver_hold)
            begin
                out_stall <= 1'b1;
                repeat (150) @(posedge clk);
                receiver_hold = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    out_steady = !out_steady;
                pause = pick_gap(out_steady);
                if (pause > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (pause) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // Compare each delivered request with the oldest expectation.
    always @(posedge clk)
    begin : delivery_check
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_deliveries.size() == 0)
            begin
                $error("unexpected delivery: out_byte %0h status %0d", out_byte, status);
                fault_count++;
            end
            else
            begin
                want = expected_deliveries.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %0h, got %0h", want.data, out_byte);
                    fault_count++;
                end
                if (msg_type !== want.msg_type)
                begin
                    $error("msg_type: expected %0h, got %0h", want.msg_type, msg_type);
                    fault_count++;
                end
                if (first_of_msg !== want.first_flag)
                begin
                    $error("first_of_msg: expected %0b, got %0b", want.first_flag, first_of_msg);
                    fault_count++;
                end
                if (last_of_msg !== want.last_flag)
                begin
                    $error("last_of_msg: expected %0b, got %0b", want.last_flag, last_of_msg);
                    fault_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int          lens[$];
        int          pick;
        logic [31:0] size;
        logic [31:0] inner_size;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        data_byte      = '0;
        max_size_reg   = 32'd65535;
        batch_type_reg = 32'd0;
        parse_at       = MODE_OUTER_HDR;
        frame_left     = '0;
        msg_left       = '0;
        msg_type_now   = '0;
        stream_halted  = 1'b0;
        bytes_offered  = 0;
        fault_count    = 0;
        in_steady      = 1'b0;
        out_steady     = 1'b0;
        receiver_hold  = 1'b0;
        clear_frame_hdr();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset register values.
        foreach (directed_rows[r])
        begin
            lens.delete();
            if (directed_rows[r].envelope)
            begin
                if (directed_rows[r].inner_a >= 0)
                    lens.insert(lens.size(), directed_rows[r].inner_a);
                if (directed_rows[r].inner_b >= 0)
                    lens.insert(lens.size(), directed_rows[r].inner_b);
                put_envelope(directed_rows[r].fill, lens, directed_rows[r].tail,
                             directed_rows[r].mtype);
            end
            else
                put_plain(directed_rows[r].size, directed_rows[r].mtype,
                          directed_rows[r].fill, 1'b0);
            send_frame();
        end

        // All-ones registers: no size limit, batch type at its top value.
        settle();
        write_register(REG_BATCH_TYPE, 32'hFFFF_FFFF);
        write_register(REG_MAX_MESSAGE_SIZE, 32'hFFFF_FFFF);
        run_random(15, 1'b0);

        // Smallest size limit: only frames up to 12 bytes and bare envelopes.
        settle();
        write_register(REG_MAX_MESSAGE_SIZE, 32'd12);
        write_register(REG_BATCH_TYPE, $urandom);
        run_random(10, 1'b0);

        // Back to the defaults; the receiver holds off while a long frame keeps coming.
        settle();
        write_register(REG_MAX_MESSAGE_SIZE, 32'd65535);
        write_register(REG_BATCH_TYPE, 32'd0);
        receiver_hold = 1'b1;
        in_steady     = 1'b1;
        put_plain(32'd24, 32'h0000_0042, 8'h00, 1'b1);
        send_frame();
        in_steady     = 1'b0;
        settle();

        // An error halts the block until reset, so exactly one closes the run.
        pick = $urandom_range(0, 3);
        case (CLOSING_CODES[pick])
            STATUS_BAD_OUTER:
            begin
                if ($urandom_range(0, 1) == 0)
                    size = max_size_reg + 1;
                else
                    size = $urandom_range(0, 7);
                put_header(size, $urandom);
            end
            STATUS_SHORT_ENV:
                put_header($urandom_range(8, 11), batch_type_reg);
            STATUS_BAD_INNER:
            begin
                size = 20 + $urandom_range(0, 8);
                put_header(size, batch_type_reg);
                repeat (4)
                    add_stream_byte(8'h00);
                if ($urandom_range(0, 1) == 0)
                    inner_size = $urandom_range(0, 7);
                else
                    inner_size = size - 11 + $urandom_range(0, 50);
                put_header(inner_size, $urandom);
            end
            default:
            begin
                put_header(ENVELOPE_PREFIX_BYTES + $urandom_range(0, 20), batch_type_reg);
                add_stream_byte(8'h01);
            end
        endcase
        for (int i = 0; i < frame_bytes.size() - 1; i++)
            offer_byte(frame_bytes[i]);
        offer_byte(frame_bytes[frame_bytes.size() - 1], 1'b1,
                   '{data: 8'h00, msg_type: 32'h0, first_flag: 1'b0, last_flag: 1'b0,
                     status: CLOSING_CODES[pick]});
        frame_bytes.delete();
        // Bytes after the error are taken and dropped.
        repeat (5)
            offer_byte(8'($urandom));
        settle();
        repeat (16) @(posedge clk);

        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
